// File: rtl/core/i2crc_pkg.sv
package i2crc_pkg;

    // bus event codes
    localparam logic [1:0] CMD_START_WRITE  = 2'd0;
    localparam logic [1:0] CMD_START_READ   = 2'd1;
    localparam logic [1:0] CMD_BYTE_WRITTEN = 2'd2;
    localparam logic [1:0] CMD_BYTE_READ    = 2'd3;

    // CRC-8 SAE J1850, MSB first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h1D;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // target address after reset
    localparam logic [6:0] DEV_ADDR_RESET = 7'd8;

    // write count saturates here
    localparam logic [1:0] WCNT_MAX = 2'd2;

    // one read byte in flight between the request and the result register
    typedef struct packed {
        logic       valid;
        logic       is_crc;   // second or later byte of the read
        logic [7:0] ptr;      // pointer at request time
        logic       oob;      // pointer beyond the store
        logic       vld;      // entry written since reset
        logic [7:0] crc_part; // CRC over address byte and pointer
    } t_rd_req;

    // one byte through the CRC, bit by bit
    function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// File: rtl/core/i2crc_ram.sv
module i2crc_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held when not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/i2crc_front.sv
module i2crc_front #(
    parameter int unsigned NUM_REGISTERS = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [1:0]            i_cmd,
    input  logic [7:0]            i_write_data,
    input  logic                  i_cfg_valid,
    input  logic [6:0]            i_cfg_data,
    input  logic                  i_req_adv,
    output i2crc_pkg::t_rd_req    o_req,
    output logic [7:0]            o_ram_q
);

    localparam int unsigned IDX_W = $clog2(NUM_REGISTERS);
    localparam logic [8:0]  NREG  = 9'(NUM_REGISTERS);

    logic [7:0]               r_ptr, n_ptr;
    logic [1:0]               r_wcnt, n_wcnt;
    logic                     r_rcnt, n_rcnt;
    logic [7:0]               r_addr_crc;
    logic [NUM_REGISTERS-1:0] r_vld;
    i2crc_pkg::t_rd_req       r_req, n_req;

    logic             oob;
    logic [IDX_W-1:0] idx;
    logic             is_wr, is_rd, store_we;

    assign oob      = {1'b0, r_ptr} >= NREG;
    assign idx      = r_ptr[IDX_W-1:0];
    assign is_wr    = i_accept && (i_cmd == i2crc_pkg::CMD_BYTE_WRITTEN);
    assign is_rd    = i_accept && (i_cmd == i2crc_pkg::CMD_BYTE_READ);
    assign store_we = is_wr && (r_wcnt == 2'd1) && !oob;

    // transfer state: pointer and byte counts
    always_comb begin
        n_ptr  = r_ptr;
        n_wcnt = r_wcnt;
        n_rcnt = r_rcnt;
        if (i_accept) begin
            case (i_cmd)
                i2crc_pkg::CMD_START_WRITE: begin
                    n_wcnt = 2'd0;
                end
                i2crc_pkg::CMD_START_READ: begin
                    n_rcnt = 1'b0;
                end
                i2crc_pkg::CMD_BYTE_WRITTEN: begin
                    if (r_wcnt == 2'd0) begin
                        n_ptr = i_write_data;
                    end
                    if (r_wcnt != i2crc_pkg::WCNT_MAX) begin
                        n_wcnt = r_wcnt + 2'd1;
                    end
                end
                i2crc_pkg::CMD_BYTE_READ: begin
                    n_rcnt = 1'b1;
                end
                default: begin
                    n_ptr = r_ptr;
                end
            endcase
        end
    end

    // read request slot
    always_comb begin
        n_req = r_req;
        if (is_rd) begin
            n_req.valid    = 1'b1;
            n_req.is_crc   = r_rcnt;
            n_req.ptr      = r_ptr;
            n_req.oob      = oob;
            n_req.vld      = r_vld[idx];
            n_req.crc_part = i2crc_pkg::crc_byte(r_addr_crc, r_ptr);
        end else if (i_req_adv) begin
            n_req.valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= 8'd0;
            r_wcnt      <= 2'd0;
            r_rcnt      <= 1'b0;
            r_addr_crc  <= i2crc_pkg::crc_byte(i2crc_pkg::CRC_INIT,
                                               {i2crc_pkg::DEV_ADDR_RESET, 1'b1});
            r_vld       <= '0;
            r_req.valid <= 1'b0;
        end else begin
            r_ptr       <= n_ptr;
            r_wcnt      <= n_wcnt;
            r_rcnt      <= n_rcnt;
            r_req.valid <= n_req.valid;
            if (i_cfg_valid) begin
                r_addr_crc <= i2crc_pkg::crc_byte(i2crc_pkg::CRC_INIT, {i_cfg_data, 1'b1});
            end
            if (store_we) begin
                r_vld[idx] <= 1'b1;
            end
        end
        // request payload, no reset
        r_req.is_crc   <= n_req.is_crc;
        r_req.ptr      <= n_req.ptr;
        r_req.oob      <= n_req.oob;
        r_req.vld      <= n_req.vld;
        r_req.crc_part <= n_req.crc_part;
    end

    assign o_req = r_req;

    // store write and read ports
    i2crc_ram #(
        .WIDTH (8),
        .DEPTH (NUM_REGISTERS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (idx),
        .i_wdata (i_write_data),
        .i_re    (is_rd),
        .i_raddr (idx),
        .o_rdata (o_ram_q)
    );

endmodule

// File: rtl/core/i2crc_back.sv
module i2crc_back #(
    parameter int unsigned ID_RESET_VALUE = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  i2crc_pkg::t_rd_req i_req,
    input  logic [7:0]         i_ram_q,
    input  logic               i_stall,
    output logic               o_req_adv,
    output logic               o_valid,
    output logic [7:0]         o_read_data,
    output logic               o_is_crc
);

    logic       r_valid, n_valid;
    logic [7:0] r_read_data;
    logic       r_is_crc;
    logic [7:0] val;
    logic [7:0] crc;

    // register value: out of range reads zero, unwritten entries read their reset value
    always_comb begin
        if (i_req.oob) begin
            val = 8'd0;
        end else if (i_req.vld) begin
            val = i_ram_q;
        end else if (i_req.ptr == 8'd0) begin
            val = 8'(ID_RESET_VALUE);
        end else begin
            val = 8'd0;
        end
    end

    assign crc       = i2crc_pkg::crc_byte(i_req.crc_part, val);
    assign o_req_adv = i_req.valid && (!r_valid || !i_stall);

    // result register handshake
    always_comb begin
        if (o_req_adv) begin
            n_valid = 1'b1;
        end else if (!i_stall) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_req_adv) begin
            r_read_data <= i_req.is_crc ? crc : val;
            r_is_crc    <= i_req.is_crc;
        end
    end

    assign o_valid     = r_valid;
    assign o_read_data = r_read_data;
    assign o_is_crc    = r_is_crc;

endmodule

// File: rtl/core/i2c_regfile_crc8_readback.sv
// I2C target register file with CRC-8 (SAE J1850) protected reads. Each beat on
// the input channel is one bus event (start of write, start of read, byte written,
// byte read); only a byte-read event produces a result beat. One event can be
// taken every clock while input stall is low. A read result passes the read slot,
// filled with the registered read of the register store, and then the CRC byte
// and the result register. Input stall rises only when the read slot is
// full and the result register cannot drain. The store comes up out of reset
// at once, without a clearing pass: a valid bit per entry makes unwritten
// entries read as zero, and register 0 as ID_RESET_VALUE. The configuration
// channel is always ready and sets the 7-bit target address used in the CRC.
module i2c_regfile_crc8_readback #(
    parameter int unsigned NUM_REGISTERS  = 256,
    parameter int unsigned ID_RESET_VALUE = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_cmd,
    input  logic [7:0] i_write_data,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_read_data,
    output logic       o_is_crc,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data
);

    i2crc_pkg::t_rd_req req;
    logic               req_adv;
    logic               accept;
    logic [7:0]         ram_q;

    // input side waits only while the read slot cannot move on
    assign o_stall     = req.valid && !req_adv;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    i2crc_front #(
        .NUM_REGISTERS (NUM_REGISTERS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_cmd        (i_cmd),
        .i_write_data (i_write_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_req_adv    (req_adv),
        .o_req        (req),
        .o_ram_q      (ram_q)
    );

    i2crc_back #(
        .ID_RESET_VALUE (ID_RESET_VALUE)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req),
        .i_ram_q     (ram_q),
        .i_stall     (i_stall),
        .o_req_adv   (req_adv),
        .o_valid     (o_valid),
        .o_read_data (o_read_data),
        .o_is_crc    (o_is_crc)
    );

    // a read event always lands in the read slot
    a_rd_to_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && (i_cmd == i2crc_pkg::CMD_BYTE_READ) |=> req.valid)
        else $error("read event did not reach the read slot");

    // a slot that moves on always fills the result register
    a_slot_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_adv |=> o_valid)
        else $error("read slot advanced without a result");

    // no new event while a read waits behind a stalled result
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req.valid && o_valid && i_stall |-> !accept)
        else $error("event accepted over a blocked read slot");

endmodule

// File: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned NUM_REGS       = 256;
    localparam int unsigned ID_VALUE       = 32;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          PHASE_ITEMS    = 170;
    localparam int          NUM_PHASES     = 6;
    localparam int          SETTLE_CYCLES  = 8;
    localparam int          HOLD_CYCLES    = 64;
    localparam int          NUM_ROWS       = 25;

    // one byte returned to the controller
    typedef struct packed {
        logic [7:0] data;
        logic       is_crc;
    } t_readback;

    // directed event, with a typed-in readback where it is obvious
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] data;
        logic       typed;
        logic [7:0] exp_data;
        logic       exp_crc;
    } t_bus_row;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic       o_stall;
    logic [1:0] i_cmd        = i2crc_pkg::CMD_START_WRITE;
    logic [7:0] i_write_data = 8'h00;
    logic       o_valid;
    logic       i_stall      = 1'b0;
    logic [7:0] o_read_data;
    logic       o_is_crc;
    logic       i_cfg_valid  = 1'b0;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data   = 7'd0;

    // predicted device state
    logic [7:0] reg_image [NUM_REGS];
    logic [7:0] reg_pointer;
    logic [1:0] wr_count;
    logic       rd_count;
    logic [6:0] dev_addr;

    t_readback readback_q [$];
    int        n_fail      = 0;
    int        items_sent  = 0;
    int        idle_cycles = 0;
    int        hold_asked  = 0;
    int        hold_served = 0;
    int        stall_left  = 0;
    int        hold_left   = 0;
    bit        calm        = 1'b0;

    t_bus_row directed_rows [NUM_ROWS] = '{
        // reads straight after reset, no start seen
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b1, 8'h20, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'hFF, 1'b0, 8'h00, 1'b0},
        // top register, trailing bytes ignored
        '{i2crc_pkg::CMD_START_WRITE,  8'hFF, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'hA5, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'h3C, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_START_READ,   8'hFF, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b1, 8'hA5, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h55, 1'b0, 8'h00, 1'b0},
        // overwrite the id register
        '{i2crc_pkg::CMD_START_WRITE,  8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'hFF, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_START_READ,   8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b1, 8'hFF, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b0, 8'h00, 1'b0},
        // never-written entry reads zero
        '{i2crc_pkg::CMD_START_WRITE,  8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'h5A, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_START_READ,   8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b1, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b0, 8'h00, 1'b0},
        // data byte without a fresh start still lands
        '{i2crc_pkg::CMD_BYTE_WRITTEN, 8'h81, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_START_READ,   8'h00, 1'b0, 8'h00, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b1, 8'h81, 1'b0},
        '{i2crc_pkg::CMD_BYTE_READ,    8'h00, 1'b0, 8'h00, 1'b0}
    };

    i2c_regfile_crc8_readback #(
        .NUM_REGISTERS (NUM_REGS),
        .ID_RESET_VALUE(ID_VALUE)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cmd       (i_cmd),
        .i_write_data(i_write_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_read_data (o_read_data),
        .o_is_crc    (o_is_crc),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // CRC-8 J1850 over address byte, pointer and value, shifted bit by bit
    function automatic logic [7:0] crc8_j1850(input logic [23:0] msg);
        logic [7:0] r;
        logic       fb;
        r = i2crc_pkg::CRC_INIT;
        for (int i = 23; i >= 0; i--) begin
            fb = r[7] ^ msg[i];
            r  = {r[6:0], 1'b0};
            if (fb) begin
                r = r ^ i2crc_pkg::CRC_POLY;
            end
        end
        return r;
    endfunction

    // advance the predicted state by one bus event; 1 when a byte comes back
    function automatic bit predict_bus_event(input logic [1:0] cmd, input logic [7:0] data,
                                             output t_readback rb);
        logic [7:0] value;
        rb    = '0;
        value = (int'(reg_pointer) < NUM_REGS) ? reg_image[reg_pointer] : 8'h00;
        case (cmd)
            i2crc_pkg::CMD_START_WRITE: begin
                wr_count = 2'd0;
                return 1'b0;
            end
            i2crc_pkg::CMD_START_READ: begin
                rd_count = 1'b0;
                return 1'b0;
            end
            i2crc_pkg::CMD_BYTE_WRITTEN: begin
                if (wr_count == 2'd0) begin
                    reg_pointer = data;
                end else if (wr_count == 2'd1 && int'(reg_pointer) < NUM_REGS) begin
                    reg_image[reg_pointer] = data;
                end
                if (wr_count < i2crc_pkg::WCNT_MAX) begin
                    wr_count = wr_count + 2'd1;
                end
                return 1'b0;
            end
            default: begin
                if (!rd_count) begin
                    rb.data   = value;
                    rb.is_crc = 1'b0;
                    rd_count  = 1'b1;
                end else begin
                    rb.data   = crc8_j1850({dev_addr, 1'b1, reg_pointer, value});
                    rb.is_crc = 1'b1;
                end
                return 1'b1;
            end
        endcase
    endfunction

    // offer one event after a random gap, hold it until taken
    task automatic send_event(input logic [1:0] cmd, input logic [7:0] data,
                              input bit typed, input t_readback typed_rb);
        int        gap;
        bit        has;
        t_readback rb;
        gap = calm ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_write_data <= data;
        do @(posedge i_clk); while (o_stall);
        has = predict_bus_event(cmd, data, rb);
        if (has) begin
            readback_q.push_back(typed ? typed_rb : rb);
        end
        items_sent++;
    endtask

    // sender pause: wait for every pending readback, then let writes settle
    task automatic wait_readbacks_done();
        i_valid <= 1'b0;
        while (readback_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_device_address(input logic [6:0] addr);
        wait_readbacks_done();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= addr;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dev_addr = addr;
    endtask

    // mostly well-formed transfers with random content, some noise
    task automatic run_random_traffic(input int count);
        int         target;
        int         pick;
        int         n;
        logic [7:0] ptr;
        target = items_sent + count;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            ptr  = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 7))
                                              : 8'($urandom_range(0, 255));
            if (pick < 45) begin
                send_event(i2crc_pkg::CMD_START_WRITE, 8'($urandom_range(0, 255)), 1'b0, '0);
                send_event(i2crc_pkg::CMD_BYTE_WRITTEN, ptr, 1'b0, '0);
                send_event(i2crc_pkg::CMD_BYTE_WRITTEN, 8'($urandom_range(0, 255)), 1'b0, '0);
                n = $urandom_range(0, 2);
                repeat (n) send_event(i2crc_pkg::CMD_BYTE_WRITTEN,
                                      8'($urandom_range(0, 255)), 1'b0, '0);
            end else if (pick < 82) begin
                send_event(i2crc_pkg::CMD_START_WRITE, 8'($urandom_range(0, 255)), 1'b0, '0);
                send_event(i2crc_pkg::CMD_BYTE_WRITTEN, ptr, 1'b0, '0);
                send_event(i2crc_pkg::CMD_START_READ, 8'($urandom_range(0, 255)), 1'b0, '0);
                n = $urandom_range(1, 4);
                repeat (n) send_event(i2crc_pkg::CMD_BYTE_READ,
                                      8'($urandom_range(0, 255)), 1'b0, '0);
            end else if (pick < 97) begin
                n = $urandom_range(1, 4);
                repeat (n) send_event(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                      1'b0, '0);
            end else begin
                wait_readbacks_done();
            end
        end
    endtask

    task automatic check_readback();
        t_readback want;
        if (readback_q.size() == 0) begin
            $error("unexpected readback: read_data %02h is_crc %0b", o_read_data, o_is_crc);
            n_fail++;
        end else begin
            want = readback_q.pop_front();
            if (o_read_data !== want.data) begin
                $error("read_data: expected %02h, got %02h", want.data, o_read_data);
                n_fail++;
            end
            if (o_is_crc !== want.is_crc) begin
                $error("is_crc: expected %0b, got %0b", want.is_crc, o_is_crc);
                n_fail++;
            end
        end
    endtask

    // result side: check each beat, random stalls, long hold on request
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_readback();
            stall_left = calm ? 0 : $urandom_range(0, 3);
        end
        if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // no beat on any channel for too long
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        logic [6:0] addr;
        t_readback  typed_rb;

        foreach (reg_image[i]) begin
            reg_image[i] = 8'h00;
        end
        reg_image[0] = 8'(ID_VALUE);
        reg_pointer  = 8'h00;
        wr_count     = 2'd0;
        rd_count     = 1'b0;
        dev_addr     = i2crc_pkg::DEV_ADDR_RESET;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed events at the reset address
        foreach (directed_rows[i]) begin
            typed_rb.data   = directed_rows[i].exp_data;
            typed_rb.is_crc = directed_rows[i].exp_crc;
            send_event(directed_rows[i].cmd, directed_rows[i].data,
                       directed_rows[i].typed, typed_rb);
        end

        // phases over target addresses, extremes first
        for (int p = 0; p < NUM_PHASES; p++) begin
            addr = (p == 0) ? 7'd0 : (p == 1) ? 7'd127 : 7'($urandom_range(0, 127));
            write_device_address(addr);
            calm = (p == 2);
            if (p == 1) begin
                // fill the block while the result side holds off
                hold_asked++;
                repeat (24) send_event(i2crc_pkg::CMD_BYTE_READ,
                                       8'($urandom_range(0, 255)), 1'b0, '0);
                wait_readbacks_done();
            end
            run_random_traffic(PHASE_ITEMS);
        end
        calm = 1'b0;

        // drain, bounded, then report anything still owed
        i_valid <= 1'b0;
        for (int k = 0; k < 500 && readback_q.size() != 0; k++) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (readback_q.size() != 0) begin
            typed_rb = readback_q.pop_front();
            $error("missing readback: read_data %02h is_crc %0b", typed_rb.data,
                   typed_rb.is_crc);
            n_fail++;
        end

        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
